// File: src/ncs_pkg.sv
// Shared constants, codes and types of the nested conditional stack.
`timescale 1ns / 1ps
`default_nettype none

package ncs_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int OP_W    = 3;
    localparam int DEPTH_W = 9;
    localparam int ERR_W   = 3;
    localparam int FLAG_W  = 4;

    // Bit positions inside one frame.
    localparam int FLAG_COND   = 0;
    localparam int FLAG_PARENT = 1;
    localparam int FLAG_ELSE   = 2;
    localparam int FLAG_TERM   = 3;

    localparam logic [OP_W-1:0] OP_IF     = 3'd0;
    localparam logic [OP_W-1:0] OP_ELSE   = 3'd1;
    localparam logic [OP_W-1:0] OP_ELSEIF = 3'd2;
    localparam logic [OP_W-1:0] OP_ENDIF  = 3'd3;
    localparam logic [OP_W-1:0] OP_UNWIND = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNEXP_ELSE = 3'd1;
    localparam logic [ERR_W-1:0] ERR_DUP_ELSE   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_UNEXP_END  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW   = 3'd4;

    typedef logic [FLAG_W-1:0] t_flags;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_flags            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// File: src/ncs_if.sv
// Valid/ready channel interfaces for directive items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface ncs_in_if;
    import ncs_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic               cond_value;
    logic [DEPTH_W-1:0] target_depth;

    modport source (output valid, output operation, output cond_value,
                    output target_depth, input ready);
    modport sink   (input valid, input operation, input cond_value,
                    input target_depth, output ready);
endinterface

interface ncs_out_if;
    import ncs_pkg::*;

    logic               valid;
    logic               ready;
    logic               overall_cond;
    logic [DEPTH_W-1:0] nest_depth;
    logic [ERR_W-1:0]   error_code;

    modport source (output valid, output overall_cond, output nest_depth,
                    output error_code, input ready);
    modport sink   (input valid, input overall_cond, input nest_depth,
                    input error_code, output ready);
endinterface

`default_nettype wire

// File: src/nested_conditional_stack.sv
// Top level of the nested conditional stack.
`timescale 1ns / 1ps
`default_nettype none

// Tracks nested if/else/elseif/endif frames and reports, for every directive
// item, whether code at the current nesting is active, the stack depth and an
// error code. The top frame sits in a register and the frames below it in a
// single-port-write, registered-read memory. Open if, else, elseif, unknown
// codes and an unwind whose target is at or above the depth go straight to the
// done state, which loads the output register and returns to idle. Endif and
// unwind pop frames in turn: each pop reads the new top from memory, then loads
// it (pop state, then load state); a pop that empties the stack needs no load.
// An endif on an empty stack goes from the pop state to the done state with an
// error. The next item is accepted only once the block is back in idle. A new
// item is accepted while the previous result still waits at the output
// register. Its result then waits until that register is free.
module nested_conditional_stack (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ncs_in_if.sink    i_in,
    ncs_out_if.source o_out
);
    import ncs_pkg::*;

    t_mem_req mem_req;
    t_flags   mem_rdata;

    ncs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_mem_req (mem_req),
        .i_rdata   (mem_rdata)
    );

    ncs_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: src/ncs_ram.sv
// Frame memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ncs_ram (
    input  logic               i_clk,
    input  ncs_pkg::t_mem_req  i_req,
    output ncs_pkg::t_flags    o_rdata
);
    import ncs_pkg::*;

    t_flags r_mem [STACK_DEPTH];
    t_flags r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/ncs_ctrl.sv
// Sequencer: keeps the top frame in a register, spills lower frames to memory.
`timescale 1ns / 1ps
`default_nettype none

module ncs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ncs_in_if.sink            i_in,
    ncs_out_if.source         o_out,
    output ncs_pkg::t_mem_req o_mem_req,
    input  ncs_pkg::t_flags   i_rdata
);
    import ncs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         r_state,    n_state;
    logic [CNT_W-1:0]   r_count,    n_count;
    t_flags             r_top,      n_top;
    logic               r_active,   n_active;
    logic               r_unwind,   n_unwind;
    logic [DEPTH_W-1:0] r_target,   n_target;
    logic [ERR_W-1:0]   r_err,      n_err;
    logic               r_more,     n_more;
    logic               r_out_valid, n_out_valid;
    logic               r_out_cond,  n_out_cond;
    logic [DEPTH_W-1:0] r_out_depth, n_out_depth;
    logic [ERR_W-1:0]   r_out_err,   n_out_err;

    logic   empty;
    logic   full;
    logic   overall;
    t_flags else_flags;

    assign empty   = (r_count == '0);
    assign full    = (r_count == CNT_W'(STACK_DEPTH));
    assign overall = empty | (r_top[FLAG_COND] & r_top[FLAG_PARENT]);

    always_comb begin
        else_flags            = r_top;
        else_flags[FLAG_ELSE] = 1'b1;
        else_flags[FLAG_COND] = ~r_top[FLAG_COND];
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.overall_cond = r_out_cond;
    assign o_out.nest_depth   = r_out_depth;
    assign o_out.error_code   = r_out_err;

    always_comb begin
        t_flags           v_base;
        t_flags           v_new;
        logic             v_act;
        logic             v_term;
        logic             v_push;
        logic [ERR_W-1:0] v_err;
        logic [CNT_W-1:0] v_cnt;
        logic             v_more;

        n_state     = r_state;
        n_count     = r_count;
        n_top       = r_top;
        n_active    = r_active;
        n_unwind    = r_unwind;
        n_target    = r_target;
        n_err       = r_err;
        n_more      = r_more;
        n_out_valid = r_out_valid;
        n_out_cond  = r_out_cond;
        n_out_depth = r_out_depth;
        n_out_err   = r_out_err;
        o_mem_req   = '0;

        v_base = r_top;
        v_new  = '0;
        v_act  = r_active;
        v_term = 1'b1;
        v_push = 1'b0;
        v_err  = ERR_NONE;
        v_cnt  = r_count - CNT_W'(1);
        v_more = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_unwind = (i_in.operation == OP_UNWIND);
                    n_target = i_in.target_depth;
                    n_state  = S_DONE;
                    case (i_in.operation)
                        OP_IF: begin
                            v_push = 1'b1;
                        end
                        OP_ELSE: begin
                            if (empty) begin
                                v_err = ERR_UNEXP_ELSE;
                            end else begin
                                v_base = else_flags;
                                if (r_top[FLAG_ELSE]) v_err = ERR_DUP_ELSE;
                            end
                        end
                        OP_ELSEIF: begin
                            v_push = 1'b1;
                            v_term = 1'b0;
                            if (empty) begin
                                v_err = ERR_UNEXP_ELSE;
                                v_act = 1'b1;
                            end else begin
                                v_base = else_flags;
                                v_act  = else_flags[FLAG_COND] & else_flags[FLAG_PARENT];
                                if (r_top[FLAG_ELSE]) v_err = ERR_DUP_ELSE;
                            end
                        end
                        OP_ENDIF: begin
                            n_state = S_POP;
                        end
                        OP_UNWIND: begin
                            if (32'(r_count) > 32'(i_in.target_depth)) begin
                                n_state = S_POP;
                            end
                        end
                        default: begin
                        end
                    endcase

                    n_top = v_base;
                    if (v_push) begin
                        if (full) begin
                            if (v_err == ERR_NONE) v_err = ERR_OVERFLOW;
                        end else begin
                            v_new[FLAG_TERM]   = v_term;
                            v_new[FLAG_PARENT] = v_act;
                            v_new[FLAG_COND]   = v_act & i_in.cond_value;
                            // The old top frame moves into memory under the new one.
                            if (!empty) begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = ADDR_W'(v_cnt);
                                o_mem_req.wdata = v_base;
                            end
                            n_top   = v_new;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    n_err = v_err;
                end
            end
            S_POP: begin
                if (empty) begin
                    n_err   = ERR_UNEXP_END;
                    n_state = S_DONE;
                end else begin
                    // A run goes on past frames without a terminator; an unwind
                    // starts another run while the depth is above the target.
                    v_more  = ~r_top[FLAG_TERM] |
                              (r_unwind & (32'(v_cnt) > 32'(r_target)));
                    n_count = v_cnt;
                    if (v_cnt != '0) begin
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = ADDR_W'(v_cnt - CNT_W'(1));
                        n_more          = v_more;
                        n_state         = S_LOAD;
                    end else begin
                        if (v_more) n_err = ERR_UNEXP_END;
                        n_state = S_DONE;
                    end
                end
            end
            S_LOAD: begin
                n_top   = i_rdata;
                n_state = r_more ? S_POP : S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cond  = overall;
                    n_out_depth = DEPTH_W'(r_count);
                    n_out_err   = r_err;
                    n_active    = overall;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_active    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top       <= n_top;
        r_unwind    <= n_unwind;
        r_target    <= n_target;
        r_err       <= n_err;
        r_more      <= n_more;
        r_out_cond  <= n_out_cond;
        r_out_depth <= n_out_depth;
        r_out_err   <= n_out_err;
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench of the nested conditional stack.
`timescale 1ns / 1ps

module testbench;
    import ncs_pkg::*;

    localparam int PRINT_CAP    = 40;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 590;
    localparam int N_ROWS       = 25;

    // Codes 5 to 7 have no meaning and must leave the stack alone.
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               cv;
        logic [DEPTH_W-1:0] target;
    } t_directive;

    typedef struct packed {
        logic               cond;
        logic [DEPTH_W-1:0] depth;
        logic [ERR_W-1:0]   err;
    } t_status;

    typedef struct packed {
        t_directive dir;
        logic       known;
        t_status    want;
    } t_row;

    // Directed part: error codes, empty stack, inactive nesting, unwinds.
    localparam t_row DIRECTED [N_ROWS] = '{
        '{'{OP_ELSE,       1'b0, 9'd0},   1'b1, '{1'b1, 9'd0, ERR_UNEXP_ELSE}},
        '{'{OP_ENDIF,      1'b0, 9'd0},   1'b1, '{1'b1, 9'd0, ERR_UNEXP_END}},
        '{'{OP_UNWIND,     1'b0, 9'd0},   1'b1, '{1'b1, 9'd0, ERR_NONE}},
        '{'{OP_RSVD_FIRST, 1'b1, 9'd0},   1'b1, '{1'b1, 9'd0, ERR_NONE}},
        '{'{OP_RSVD_LAST,  1'b1, 9'd511}, 1'b1, '{1'b1, 9'd0, ERR_NONE}},
        '{'{OP_ELSEIF,     1'b1, 9'd0},   1'b1, '{1'b1, 9'd1, ERR_UNEXP_ELSE}},
        '{'{OP_ENDIF,      1'b0, 9'd0},   1'b1, '{1'b1, 9'd0, ERR_UNEXP_END}},
        '{'{OP_IF,         1'b1, 9'd0},   1'b1, '{1'b1, 9'd1, ERR_NONE}},
        '{'{OP_IF,         1'b0, 9'd0},   1'b1, '{1'b0, 9'd2, ERR_NONE}},
        '{'{OP_IF,         1'b1, 9'd0},   1'b0, '0},
        '{'{OP_ELSE,       1'b0, 9'd0},   1'b0, '0},
        '{'{OP_ELSE,       1'b0, 9'd0},   1'b1, '{1'b0, 9'd3, ERR_DUP_ELSE}},
        '{'{OP_ENDIF,      1'b0, 9'd0},   1'b0, '0},
        '{'{OP_ELSE,       1'b1, 9'd0},   1'b0, '0},
        '{'{OP_ELSEIF,     1'b1, 9'd0},   1'b1, '{1'b0, 9'd3, ERR_DUP_ELSE}},
        '{'{OP_ENDIF,      1'b0, 9'd0},   1'b0, '0},
        '{'{OP_IF,         1'b1, 9'd0},   1'b0, '0},
        '{'{OP_ELSEIF,     1'b1, 9'd0},   1'b0, '0},
        '{'{OP_ELSEIF,     1'b0, 9'd0},   1'b0, '0},
        '{'{OP_UNWIND,     1'b0, 9'd511}, 1'b0, '0},
        '{'{OP_UNWIND,     1'b1, 9'd2},   1'b0, '0},
        '{'{OP_IF,         1'b0, 9'd0},   1'b0, '0},
        '{'{OP_UNWIND,     1'b0, 9'd0},   1'b1, '{1'b1, 9'd0, ERR_NONE}},
        '{'{OP_ELSEIF,     1'b0, 9'd0},   1'b1, '{1'b0, 9'd1, ERR_UNEXP_ELSE}},
        '{'{OP_UNWIND,     1'b0, 9'd0},   1'b1, '{1'b1, 9'd0, ERR_UNEXP_END}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ncs_in_if  dir_ch ();
    ncs_out_if stat_ch ();

    nested_conditional_stack i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (dir_ch),
        .o_out   (stat_ch)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the conditional stack.
    t_flags      frames [STACK_DEPTH];
    int unsigned frames_cnt = 0;
    logic        frames_active = 1'b1;

    t_status     status_q [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          hold_request = 0;
    int          stall_cycles = 0;

    function automatic logic cond_now();
        if (frames_cnt == 0)
            return 1'b1;
        return frames[frames_cnt-1][FLAG_COND] & frames[frames_cnt-1][FLAG_PARENT];
    endfunction

    function automatic logic [ERR_W-1:0] push_frame(input logic term, input logic cv);
        t_flags f;
        if (frames_cnt >= STACK_DEPTH)
            return ERR_OVERFLOW;
        f = '0;
        f[FLAG_TERM]   = term;
        f[FLAG_PARENT] = frames_active;
        f[FLAG_COND]   = frames_active & cv;
        frames[frames_cnt] = f;
        frames_cnt++;
        return ERR_NONE;
    endfunction

    function automatic logic [ERR_W-1:0] flip_top();
        logic [ERR_W-1:0] err;
        err = ERR_NONE;
        if (frames_cnt == 0)
            return ERR_UNEXP_ELSE;
        if (frames[frames_cnt-1][FLAG_ELSE])
            err = ERR_DUP_ELSE;
        frames[frames_cnt-1][FLAG_ELSE] = 1'b1;
        frames[frames_cnt-1][FLAG_COND] = ~frames[frames_cnt-1][FLAG_COND];
        return err;
    endfunction

    // Pops until a frame that needs a terminator has gone.
    function automatic logic [ERR_W-1:0] pop_run();
        logic term;
        forever begin
            if (frames_cnt == 0)
                return ERR_UNEXP_END;
            term = frames[frames_cnt-1][FLAG_TERM];
            frames_cnt--;
            if (term)
                return ERR_NONE;
        end
    endfunction

    function automatic t_status apply_directive(input t_directive d);
        t_status          s;
        logic [ERR_W-1:0] err;
        logic [ERR_W-1:0] step_err;
        err = ERR_NONE;
        case (d.op)
            OP_IF: begin
                err = push_frame(1'b1, d.cv);
            end
            OP_ELSE: begin
                err = flip_top();
            end
            OP_ELSEIF: begin
                err = flip_top();
                frames_active = cond_now();
                step_err = push_frame(1'b0, d.cv);
                if (err == ERR_NONE)
                    err = step_err;
            end
            OP_ENDIF: begin
                err = pop_run();
            end
            OP_UNWIND: begin
                while (frames_cnt > d.target) begin
                    step_err = pop_run();
                    if (step_err != ERR_NONE)
                        err = step_err;
                end
            end
            default: ;
        endcase
        frames_active = cond_now();
        s.cond  = frames_active;
        s.depth = DEPTH_W'(frames_cnt);
        s.err   = err;
        return s;
    endfunction

    // Mostly well-formed nesting kept below the ceiling, with some noise.
    function automatic t_directive pick_directive(input int unsigned ceiling);
        t_directive  d;
        int unsigned roll;
        d.op     = OP_IF;
        d.cv     = 1'($urandom_range(1));
        d.target = DEPTH_W'($urandom_range(511));
        if ($urandom_range(99) < 12) begin
            d.op = OP_W'($urandom_range(7));
            return d;
        end
        roll = $urandom_range(99);
        if (frames_cnt == 0 || (roll < 35 && frames_cnt < ceiling))
            d.op = OP_IF;
        else if (roll < 60 && !frames[frames_cnt-1][FLAG_ELSE])
            d.op = (roll < 48) ? OP_ELSE : OP_ELSEIF;
        else if (roll < 93)
            d.op = OP_ENDIF;
        else begin
            d.op     = OP_UNWIND;
            d.target = DEPTH_W'($urandom_range(frames_cnt - 1));
        end
        return d;
    endfunction

    task automatic send_directive(input t_directive d, input logic known = 1'b0,
                                  input t_status want = '0);
        t_status got;
        while ($urandom_range(99) < src_idle_pct) begin
            dir_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        dir_ch.valid        <= 1'b1;
        dir_ch.operation    <= d.op;
        dir_ch.cond_value   <= d.cv;
        dir_ch.target_depth <= d.target;
        @(posedge i_clk);
        while (!dir_ch.ready)
            @(posedge i_clk);
        got = apply_directive(d);
        status_q.push_back(known ? want : got);
        items_sent++;
    endtask

    task automatic wait_for_results();
        dir_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (status_q.size() != 0);
    endtask

    // Fills the stack to the top, pushes into the full stack, then unwinds.
    task automatic fill_and_unwind();
        t_directive d;
        d.op     = OP_IF;
        d.target = '0;
        while (frames_cnt < STACK_DEPTH) begin
            d.cv = ($urandom_range(15) != 0);
            send_directive(d);
        end
        d.cv = 1'($urandom_range(1));
        send_directive(d);
        d.op = OP_ELSEIF;
        send_directive(d);
        send_directive(d);
        d.op     = OP_UNWIND;
        d.target = DEPTH_W'($urandom_range(3));
        send_directive(d);
    endtask

    task automatic flag_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int hold_taken;
        int hold_left;
        hold_taken = 0;
        hold_left  = 0;
        stat_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != hold_taken) begin
                hold_taken = hold_request;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                stat_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                stat_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && stat_ch.valid && stat_ch.ready) begin
            if (status_q.size() == 0) begin
                flag_mismatch("result item with nothing expected");
            end else begin
                want = status_q.pop_front();
                if (stat_ch.overall_cond !== want.cond)
                    flag_mismatch($sformatf("overall_cond %b, expected %b",
                                            stat_ch.overall_cond, want.cond));
                if (stat_ch.nest_depth !== want.depth)
                    flag_mismatch($sformatf("nest_depth %0d, expected %0d",
                                            stat_ch.nest_depth, want.depth));
                if (stat_ch.error_code !== want.err)
                    flag_mismatch($sformatf("error_code %0d, expected %0d",
                                            stat_ch.error_code, want.err));
            end
        end
    end

    // Ends the run when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((dir_ch.valid && dir_ch.ready) || (stat_ch.valid && stat_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int phase;
        int phase_end;
        int ceiling;
        int since_pick;
        bit burst_done;
        i_rst_n             <= 1'b0;
        dir_ch.valid        <= 1'b0;
        dir_ch.operation    <= OP_IF;
        dir_ch.cond_value   <= 1'b0;
        dir_ch.target_depth <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            send_directive(DIRECTED[r].dir, DIRECTED[r].known, DIRECTED[r].want);

        ceiling    = 6;
        since_pick = 0;
        for (phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 76 : 0;
            snk_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 31 : 0;
            phase_end    = items_sent + PHASE_ITEMS;
            burst_done   = (phase == 1);
            // Hold the receiver off while items keep coming, so the block backs up.
            if (phase == 2)
                hold_request++;
            while (items_sent < phase_end) begin
                if (!burst_done && items_sent >= phase_end - PHASE_ITEMS / 2) begin
                    fill_and_unwind();
                    burst_done = 1'b1;
                end
                if (since_pick == 0)
                    ceiling = ($urandom_range(9) == 0) ? 40 : 6;
                since_pick = (since_pick + 1) % 50;
                send_directive(pick_directive(ceiling));
            end
            if (phase == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
src/ncs_pkg.sv
src/ncs_if.sv
src/ncs_ram.sv
src/ncs_ctrl.sv
src/nested_conditional_stack.sv
tb/testbench.sv
